>>> hw/rtl/br1rd_pkg.sv
// Shared types and constants for the ByteRun1 row decoder.
`default_nettype none

package br1rd_pkg;

    localparam int MAX_ROW_BYTES_DEF = 8192;
    localparam int ROW_SIZE_W        = 14;
    localparam int APB_AW            = 3;
    localparam int APB_DW            = 32;

    localparam logic [ROW_SIZE_W-1:0] ROW_SIZE_RST = 14'd40;
    localparam logic                  REG_ROW_SIZE = 1'b0;

    localparam logic [3:0] GROUP_BYTES = 4'd8;
    localparam logic [7:0] HDR_NOP     = 8'h80;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_OVERRUN = 2'd1;
    localparam logic [1:0] STATUS_TRUNC   = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte_0;
        logic [7:0] out_byte_1;
        logic [7:0] out_byte_2;
        logic [7:0] out_byte_3;
        logic [7:0] out_byte_4;
        logic [7:0] out_byte_5;
        logic [7:0] out_byte_6;
        logic [7:0] out_byte_7;
        logic [3:0] valid_count;
        logic       row_end;
        logic [1:0] status;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // consume the input request
        logic group;    // emit next repeat group
        logic tail;     // emit truncated-run close
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic slot_free;    // output register can take a result this cycle
        logic repeat_next;  // the next input byte is a repeat value
        logic lit_tail;     // the current literal byte ends the stream mid-run
        logic group_last;   // the pending repeat group is the final one
    } t_dp_sts;

endpackage

`default_nettype wire

>>> hw/rtl/br1rd_ctrl.sv
// Controller state machine of the ByteRun1 row decoder.
`default_nettype none

module br1rd_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  br1rd_pkg::t_dp_sts     i_sts,
    output br1rd_pkg::t_dp_cmd     o_cmd
);
    import br1rd_pkg::*;

    typedef enum logic [2:0] {
        ST_ACCEPT = 3'b001,
        ST_GROUP  = 3'b010,
        ST_TAIL   = 3'b100
    } t_ctl_state;

    t_ctl_state r_state;
    t_ctl_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        case (r_state)
            ST_ACCEPT: begin
                o_in_stall = ~i_sts.slot_free;
                if (i_in_valid && i_sts.slot_free) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.repeat_next) begin
                        n_state = ST_GROUP;
                    end else if (i_sts.lit_tail) begin
                        n_state = ST_TAIL;
                    end
                end
            end
            ST_GROUP: begin
                if (i_sts.slot_free) begin
                    o_cmd.group = 1'b1;
                    if (i_sts.group_last) begin
                        n_state = ST_ACCEPT;
                    end
                end
            end
            ST_TAIL: begin
                if (i_sts.slot_free) begin
                    o_cmd.tail = 1'b1;
                    n_state    = ST_ACCEPT;
                end
            end
            default: begin
                n_state = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCEPT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/br1rd_datapath.sv
// Datapath of the ByteRun1 row decoder: run and row counters, output register.
`default_nettype none

module br1rd_datapath #(
    parameter int MAX_ROW_BYTES = br1rd_pkg::MAX_ROW_BYTES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  br1rd_pkg::t_in_item                   i_in,
    input  wire logic [br1rd_pkg::ROW_SIZE_W-1:0] i_row_size,
    input  br1rd_pkg::t_dp_cmd                    i_cmd,
    output br1rd_pkg::t_dp_sts                    o_sts,
    input  wire logic                             i_out_stall,
    output logic                                  o_out_valid,
    output br1rd_pkg::t_out_item                  o_out
);
    import br1rd_pkg::*;

    localparam int FILL_W  = $clog2(MAX_ROW_BYTES);
    localparam int SUM_RAW = $clog2(MAX_ROW_BYTES + 129);
    localparam int SUM_W   = (SUM_RAW > ROW_SIZE_W) ? SUM_RAW : ROW_SIZE_W;
    localparam logic [SUM_W-1:0] MAX_LEN = SUM_W'(MAX_ROW_BYTES);

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_LITERAL = 4'b0010,
        PH_REPEAT  = 4'b0100,
        PH_SKIP    = 4'b1000
    } t_phase;

    t_phase              r_phase,      n_phase;
    logic [7:0]          r_run_left,   n_run_left;
    logic [FILL_W-1:0]   r_row_filled, n_row_filled;
    logic [7:0]          r_byte,       n_byte;
    logic                r_last,       n_last;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                n_out_load;
    t_out_item           n_out_item;
    logic                w_slot_free;

    logic [SUM_W-1:0]    w_rb;
    logic [SUM_W-1:0]    w_len;
    logic [SUM_W-1:0]    w_fill;

    logic                w_is_lit;
    logic [7:0]          w_count;
    logic [SUM_W-1:0]    w_hdr_sum;
    logic                w_overrun;

    logic [SUM_W-1:0]    w_lit_sum;
    logic                w_lit_end;
    logic [FILL_W-1:0]   w_lit_fill;
    logic                w_lit_done;

    logic [3:0]          w_take;
    logic [SUM_W-1:0]    w_grp_sum;
    logic                w_grp_end;
    logic [FILL_W-1:0]   w_grp_fill;
    logic                w_grp_done;

    function automatic t_out_item make_item(input logic [7:0] b, input logic [3:0] cnt,
                                            input logic row_end, input logic [1:0] st);
        t_out_item it;
        it.out_byte_0  = (cnt > 4'd0) ? b : 8'd0;
        it.out_byte_1  = (cnt > 4'd1) ? b : 8'd0;
        it.out_byte_2  = (cnt > 4'd2) ? b : 8'd0;
        it.out_byte_3  = (cnt > 4'd3) ? b : 8'd0;
        it.out_byte_4  = (cnt > 4'd4) ? b : 8'd0;
        it.out_byte_5  = (cnt > 4'd5) ? b : 8'd0;
        it.out_byte_6  = (cnt > 4'd6) ? b : 8'd0;
        it.out_byte_7  = (cnt > 4'd7) ? b : 8'd0;
        it.valid_count = cnt;
        it.row_end     = row_end;
        it.status      = st;
        return it;
    endfunction

    // effective row length, clamped to 1..MAX_ROW_BYTES
    always_comb begin
        w_rb   = SUM_W'(i_row_size);
        w_len  = (w_rb == '0) ? SUM_W'(1) : ((w_rb > MAX_LEN) ? MAX_LEN : w_rb);
        w_fill = SUM_W'(r_row_filled);
    end

    always_comb begin
        w_is_lit  = ~i_in.in_byte[7];
        w_count   = w_is_lit ? (i_in.in_byte + 8'd1) : 8'(9'd257 - {1'b0, i_in.in_byte});
        w_hdr_sum = w_fill + SUM_W'(w_count);
        w_overrun = w_hdr_sum > w_len;

        w_lit_sum  = w_fill + SUM_W'(1);
        w_lit_end  = w_lit_sum >= w_len;
        w_lit_fill = w_lit_end ? '0 : w_lit_sum[FILL_W-1:0];
        w_lit_done = r_run_left == 8'd1;

        w_take     = (r_run_left < 8'(GROUP_BYTES)) ? r_run_left[3:0] : GROUP_BYTES;
        w_grp_sum  = w_fill + SUM_W'(w_take);
        w_grp_end  = w_grp_sum >= w_len;
        w_grp_fill = w_grp_end ? '0 : w_grp_sum[FILL_W-1:0];
        w_grp_done = r_run_left <= 8'(GROUP_BYTES);
    end

    always_comb begin
        n_phase      = r_phase;
        n_run_left   = r_run_left;
        n_row_filled = r_row_filled;
        n_byte       = r_byte;
        n_last       = r_last;
        n_out_load   = 1'b0;
        n_out_item   = r_out;

        if (i_cmd.accept) begin
            case (r_phase)
                PH_HEADER: begin
                    if (i_in.in_byte != HDR_NOP) begin
                        if (w_overrun) begin
                            // run would cross the row end: close row, drop the run
                            n_out_load   = 1'b1;
                            n_out_item   = make_item(8'd0, 4'd0, 1'b1, STATUS_OVERRUN);
                            n_row_filled = '0;
                            n_phase      = PH_SKIP;
                            n_run_left   = w_is_lit ? w_count : 8'd1;
                        end else begin
                            n_phase    = w_is_lit ? PH_LITERAL : PH_REPEAT;
                            n_run_left = w_count;
                            if (i_in.last_byte) begin
                                n_out_load = 1'b1;
                                n_out_item = make_item(8'd0, 4'd0, 1'b1, STATUS_TRUNC);
                            end
                        end
                    end else if (i_in.last_byte && (r_row_filled != '0)) begin
                        n_out_load = 1'b1;
                        n_out_item = make_item(8'd0, 4'd0, 1'b1, STATUS_OK);
                    end
                end
                PH_LITERAL: begin
                    n_out_load   = 1'b1;
                    n_out_item   = make_item(i_in.in_byte, 4'd1,
                                             w_lit_end | (i_in.last_byte && w_lit_done &&
                                                          (w_lit_fill != '0)),
                                             STATUS_OK);
                    n_row_filled = w_lit_fill;
                    n_run_left   = r_run_left - 8'd1;
                    if (w_lit_done) begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_REPEAT: begin
                    n_byte = i_in.in_byte;
                    n_last = i_in.last_byte;
                end
                PH_SKIP: begin
                    n_run_left = r_run_left - 8'd1;
                    if (r_run_left <= 8'd1) begin
                        n_run_left = 8'd0;
                        n_phase    = PH_HEADER;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase

            // end of stream; a repeat run clears at its final group instead
            if (i_in.last_byte && (r_phase != PH_REPEAT)) begin
                n_phase      = PH_HEADER;
                n_run_left   = 8'd0;
                n_row_filled = '0;
            end
        end else if (i_cmd.group) begin
            n_out_load   = 1'b1;
            n_out_item   = make_item(r_byte, w_take,
                                     w_grp_end | (r_last && w_grp_done && (w_grp_fill != '0)),
                                     STATUS_OK);
            n_run_left   = r_run_left - 8'(w_take);
            n_row_filled = w_grp_fill;
            if (w_grp_done) begin
                n_phase    = PH_HEADER;
                n_run_left = 8'd0;
                if (r_last) begin
                    n_row_filled = '0;
                end
            end
        end else if (i_cmd.tail) begin
            n_out_load = 1'b1;
            n_out_item = make_item(8'd0, 4'd0, 1'b1, STATUS_TRUNC);
        end
    end

    assign w_slot_free = ~r_out_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_run_left   <= 8'd0;
            r_row_filled <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_run_left   <= n_run_left;
            r_row_filled <= n_row_filled;
            if (w_slot_free) begin
                r_out_valid <= n_out_load;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
        if (n_out_load) begin
            r_out <= n_out_item;
        end
    end

    always_comb begin
        o_sts.slot_free   = w_slot_free;
        o_sts.repeat_next = r_phase == PH_REPEAT;
        o_sts.lit_tail    = (r_phase == PH_LITERAL) && i_in.last_byte && !w_lit_done;
        o_sts.group_last  = w_grp_done;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

>>> hw/rtl/byterun1_row_decoder.sv
// Top level of the ByteRun1 (PackBits) row decoder with its APB register.
//
// Compressed bytes enter on the i_in channel (valid/stall), one request per
// byte; last_byte marks the end of the body. Decoded data leaves on the o_out
// channel as groups of up to eight identical or single literal bytes, with
// valid_count, row_end and status. The row length is set through the APB port.
// Timing, one output register between the sides:
//   header, literal and dropped-run bytes: the result (if any) appears in
//   the output register the cycle after the byte is taken.
//   repeat value of a run of n bytes: one group per cycle from the group
//   sequencer while the output register is free; a truncated literal adds
//   a closing result from the sequencer.
// In ST_ACCEPT the input takes a new byte whenever the output register is
// empty or drained in the same cycle. While the receiver stalls with a
// result waiting, the result holds and the input stalls, even for header bytes.
// Synchronous reset puts the row length to 40, empties the output register and
// returns the decoder to expecting a header; no clearing pass is needed.
`default_nettype none

module byterun1_row_decoder #(
    parameter int MAX_ROW_BYTES = br1rd_pkg::MAX_ROW_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  br1rd_pkg::t_in_item                i_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output br1rd_pkg::t_out_item               o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [br1rd_pkg::APB_AW-1:0]  paddr,
    input  wire logic [br1rd_pkg::APB_DW-1:0]  pwdata,
    output logic      [br1rd_pkg::APB_DW-1:0]  prdata,
    output logic                               pready
);
    import br1rd_pkg::*;

    logic [ROW_SIZE_W-1:0] r_row_size;
    logic                  w_wr;
    t_dp_cmd               w_cmd;
    t_dp_sts               w_sts;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr[2] == REG_ROW_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_size <= ROW_SIZE_RST;
        end else if (w_wr) begin
            r_row_size <= pwdata[ROW_SIZE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if ((paddr[2] == REG_ROW_SIZE) && (paddr[1:0] == 2'd0)) begin
            prdata = APB_DW'(r_row_size);
        end
    end

    br1rd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    br1rd_datapath #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_row_size  (r_row_size),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.accept, w_cmd.group, w_cmd.tail}))
        else $error("more than one datapath command at once");

    a_seq_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.group || w_cmd.tail) |-> o_in_stall)
        else $error("input taken while the group sequencer runs");

    a_err_closes_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status != STATUS_OK)) |->
            (o_out.row_end && (o_out.valid_count == 4'd0)))
        else $error("error status without an empty row close");

    a_lane_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.valid_count <= GROUP_BYTES))
        else $error("valid_count above the group size");

endmodule

`default_nettype wire

>>> tb/sv/byterun1_row_decoder_tb.sv
// Self-checking testbench for the ByteRun1 row decoder: directed and random streams.
`default_nettype none

module byterun1_row_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import br1rd_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int OUT_W          = $bits(t_out_item);
    localparam int SETTLE_CYCLES  = 20;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 6;

    typedef enum logic [1:0] {
        AT_HEADER,
        IN_LITERAL,
        IN_REPEAT,
        IN_DROP
    } t_run_phase;

    // Tracks decoder state and queues the decoded groups each request should produce.
    class decode_scoreboard;
        logic [ROW_SIZE_W-1:0]  row_size_cfg;
        t_run_phase             run_phase;
        int                     run_left;
        int                     row_filled;
        t_out_item              decoded_q[$];
        int                     errors;

        function new();
            row_size_cfg  = ROW_SIZE_RST;
            run_phase     = AT_HEADER;
            run_left      = 0;
            row_filled    = 0;
            errors        = 0;
        endfunction

        function void set_row_size(logic [ROW_SIZE_W-1:0] v);
            row_size_cfg = v;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        function t_out_item make_result(logic [7:0] v, int cnt, logic row_end,
                                        logic [1:0] st);
            t_out_item r;
            r = '0;
            r.out_byte_0  = (cnt > 0) ? v : 8'h00;
            r.out_byte_1  = (cnt > 1) ? v : 8'h00;
            r.out_byte_2  = (cnt > 2) ? v : 8'h00;
            r.out_byte_3  = (cnt > 3) ? v : 8'h00;
            r.out_byte_4  = (cnt > 4) ? v : 8'h00;
            r.out_byte_5  = (cnt > 5) ? v : 8'h00;
            r.out_byte_6  = (cnt > 6) ? v : 8'h00;
            r.out_byte_7  = (cnt > 7) ? v : 8'h00;
            r.valid_count = 4'(cnt);
            r.row_end     = row_end;
            r.status      = st;
            return r;
        endfunction

        function void note_request(t_in_item it);
            t_out_item  burst[$];
            logic [7:0] b;
            int         len;
            int         count;
            int         take;
            logic       row_done;
            b   = it.in_byte;
            len = int'(row_size_cfg);
            if (len == 0) len = 1;
            if (len > MAX_ROW_BYTES_DEF) len = MAX_ROW_BYTES_DEF;

            case (run_phase)
                AT_HEADER: begin
                    if (b != HDR_NOP) begin
                        count = (b < 8'h80) ? int'(b) + 1 : 257 - int'(b);
                        // run would cross the row end: close row, drop the run
                        if (row_filled + count > len) begin
                            burst.push_back(make_result(8'h00, 0, 1'b1, STATUS_OVERRUN));
                            row_filled = 0;
                            run_phase  = IN_DROP;
                            run_left   = (b < 8'h80) ? count : 1;
                        end else begin
                            run_phase = (b < 8'h80) ? IN_LITERAL : IN_REPEAT;
                            run_left  = count;
                        end
                    end
                end
                IN_LITERAL: begin
                    row_filled++;
                    row_done = (row_filled >= len);
                    if (row_done) row_filled = 0;
                    burst.push_back(make_result(b, 1, row_done, STATUS_OK));
                    if (run_left > 0) run_left--;
                    if (run_left == 0) run_phase = AT_HEADER;
                end
                IN_REPEAT: begin
                    while (run_left > 0 && burst.size() < 16) begin
                        take       = (run_left < int'(GROUP_BYTES)) ? run_left
                                                                     : int'(GROUP_BYTES);
                        run_left  -= take;
                        row_filled += take;
                        row_done   = (row_filled >= len);
                        if (row_done) row_filled = 0;
                        burst.push_back(make_result(b, take, row_done, STATUS_OK));
                    end
                    run_left  = 0;
                    run_phase = AT_HEADER;
                end
                default: begin
                    if (run_left > 0) run_left--;
                    if (run_left == 0) run_phase = AT_HEADER;
                end
            endcase

            if (it.last_byte) begin
                if (run_phase == IN_LITERAL || run_phase == IN_REPEAT) begin
                    burst.push_back(make_result(8'h00, 0, 1'b1, STATUS_TRUNC));
                end else if (row_filled != 0) begin
                    if (burst.size() > 0)
                        burst[burst.size()-1].row_end = 1'b1;
                    else
                        burst.push_back(make_result(8'h00, 0, 1'b1, STATUS_OK));
                end
                run_phase  = AT_HEADER;
                run_left   = 0;
                row_filled = 0;
            end

            foreach (burst[i]) decoded_q.push_back(burst[i]);
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item        want;
            logic [OUT_W-1:0] gv;
            logic [OUT_W-1:0] wv;
            if (decoded_q.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing pending", got));
                return;
            end
            want = decoded_q.pop_front();
            gv   = got;
            wv   = want;
            for (int i = 0; i < 8; i++) begin
                if (gv[OUT_W-1-8*i -: 8] !== wv[OUT_W-1-8*i -: 8])
                    report_mismatch($sformatf("out_byte_%0d got %h want %h", i,
                                              gv[OUT_W-1-8*i -: 8], wv[OUT_W-1-8*i -: 8]));
            end
            if (got.valid_count !== want.valid_count)
                report_mismatch($sformatf("valid_count got %0d want %0d",
                                          got.valid_count, want.valid_count));
            if (got.row_end !== want.row_end)
                report_mismatch($sformatf("row_end got %b want %b", got.row_end, want.row_end));
            if (got.status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
        endtask

        task flush_check();
            if (decoded_q.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", decoded_q.size()));
        endtask
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_req    = '0;
    logic                  out_stall = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_AW-1:0]     paddr     = '0;
    logic [APB_DW-1:0]     pwdata    = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    decode_scoreboard      sb = new();
    t_in_item              stream_q[$];
    bit                    in_quiet;
    bit                    out_quiet;
    bit                    hold_off_req;
    int                    idle_cycles;

    always #(CLK_PERIOD/2) clk = ~clk;

    byterun1_row_decoder u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void add_byte(logic [7:0] b, logic last);
        t_in_item it;
        it.in_byte   = b;
        it.last_byte = last;
        stream_q.push_back(it);
    endfunction

    function automatic void add_run();
        int r;
        int count;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128)
                                                : $urandom_range(1, 8);
            add_byte(8'(count - 1), 1'b0);
            repeat (count) add_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (r < 90) begin
            count = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 128)
                                                : $urandom_range(2, 24);
            add_byte(8'(257 - count), 1'b0);
            add_byte(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            add_byte(HDR_NOP, 1'b0);
        end
    endfunction

    // mostly well-formed bodies; some cut short, some left open, some noise
    function automatic void build_random(int n_items);
        int r;
        int s;
        int count;
        int k;
        while (stream_q.size() < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 85) begin
                repeat ($urandom_range(1, 8)) add_run();
                s = $urandom_range(0, 9);
                if (s < 6) begin
                    stream_q[stream_q.size()-1].last_byte = 1'b1;
                end else if (s == 6) begin
                    count = $urandom_range(2, 40);
                    k     = $urandom_range(0, count - 1);
                    add_byte(8'(count - 1), k == 0);
                    for (int i = 1; i <= k; i++)
                        add_byte(8'($urandom_range(0, 255)), i == k);
                end else if (s == 7) begin
                    add_byte(8'(257 - $urandom_range(2, 128)), 1'b1);
                end
            end else begin
                repeat ($urandom_range(1, 6))
                    add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
        end
    endfunction

    function automatic void build_directed();
        add_byte(HDR_NOP, 1'b0);
        add_byte(8'h00, 1'b0);  add_byte(8'h00, 1'b0);
        add_byte(8'h01, 1'b0);  add_byte(8'hFF, 1'b0);  add_byte(8'h7F, 1'b0);
        // repeat of 128 cannot fit the 40-byte row: overrun, value dropped
        add_byte(8'h81, 1'b0);  add_byte(8'hAB, 1'b0);
        add_byte(8'hF9, 1'b0);  add_byte(8'h55, 1'b0);
        // 8 + 32 fills the row exactly
        add_byte(8'hE1, 1'b0);  add_byte(8'hAA, 1'b0);
        // literal of 4 cut after two bytes
        add_byte(8'h03, 1'b0);  add_byte(8'h12, 1'b0);  add_byte(8'h34, 1'b1);
        // repeat header as the final byte
        add_byte(8'hFE, 1'b1);
        // body ends inside a dropped literal
        add_byte(8'h7F, 1'b0);  add_byte(8'h00, 1'b0);  add_byte(8'hFF, 1'b1);
        // partial row closed by a final no-op header
        add_byte(8'h00, 1'b0);  add_byte(8'h42, 1'b0);  add_byte(HDR_NOP, 1'b1);
        // partial row closed on the final literal / repeat byte
        add_byte(8'h00, 1'b0);  add_byte(8'h99, 1'b1);
        add_byte(8'hFF, 1'b0);  add_byte(8'hC3, 1'b1);
    endfunction

    task automatic push_request(input t_in_item it);
        int gap;
        gap = pick_gap(in_quiet);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= it;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        sb.note_request(it);
    endtask

    task automatic send_stream();
        foreach (stream_q[i]) push_request(stream_q[i]);
        in_valid <= 1'b0;
        stream_q.delete();
    endtask

    task automatic settle();
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_row_size(input logic [ROW_SIZE_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * int'(REG_ROW_SIZE));
        pwdata  <= APB_DW'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_row_size(v);
    endtask

    // receiver: checks accepted results and stalls at random
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (o_out_valid && !out_stall) sb.check_result(o_out);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_LEN;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                stall_left = pick_gap(out_quiet);
                if (stall_left > 0) begin
                    stall_left--;
                    out_stall <= 1'b1;
                end else begin
                    out_stall <= 1'b0;
                end
            end
        end
    end

    initial begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                    || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** byterun1_row_decoder: FAILED **");
        $finish;
    end

    initial begin : main_flow
        int rows[10];
        rows = '{1, 0, 8192, 16383, 3, 17, $urandom_range(1, 64),
                 $urandom_range(100, 300), 40, $urandom_range(1, 16)};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset row length of 40 first
        build_directed();
        send_stream();
        settle();

        foreach (rows[p]) begin
            write_row_size(ROW_SIZE_W'(rows[p]));
            in_quiet  = ($urandom_range(0, 3) == 0);
            out_quiet = ($urandom_range(0, 3) == 0);
            if (rows[p] == 8192) begin
                in_quiet     = 1'b1;
                hold_off_req = 1'b1;
                // longest repeat and longest literal in one wide row
                add_byte(8'h81, 1'b0);
                add_byte(8'($urandom_range(0, 255)), 1'b0);
                add_byte(8'h7F, 1'b0);
                repeat (128) add_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            build_random(PHASE_ITEMS + stream_q.size());
            // leave a partial row open so the next, shorter row length hits it
            if (rows[p] == 16383) begin
                add_byte(8'h09, 1'b0);
                repeat (10) add_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            send_stream();
            settle();
        end

        sb.flush_check();
        if (sb.errors == 0)
            $display("** byterun1_row_decoder: PASSED **");
        else
            $display("** byterun1_row_decoder: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
